FILE: rtl/core/sapc_pkg.sv
// Shared types and constants of the steering-angle PI controller.
`default_nettype none

package sapc_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned INTEGRAL_BITS_DEF = 32;
  localparam int unsigned SERVO_BITS_DEF    = 12;

  // Field and register widths.
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned ERR_W      = 17;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 12;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Every serial multiply consumes a 16-bit operand, one bit per cycle.
  localparam int unsigned MUL_STEPS = 16;

  // Static map: gain in Q.16, offset aligned to Q.29 plus the rounding half.
  localparam int unsigned MAP_GAIN_W = 27;
  localparam int unsigned MAP_ACC_W  = 46;
  localparam int unsigned MAP_SHIFT  = 29;
  localparam logic [MAP_GAIN_W-1:0] MAP_G0 = 27'd75551085;
  localparam logic [MAP_GAIN_W-1:0] MAP_G1 = 27'd89879290;
  localparam logic [MAP_ACC_W-1:0]  MAP_B0 = (46'd144268842 << 13) + (46'd1 << 28);
  localparam logic [MAP_ACC_W-1:0]  MAP_B1 = (46'd145407621 << 13) + (46'd1 << 28);

  // Regulated path scaling.
  localparam int unsigned INC_SHIFT    = 13;
  localparam int unsigned PE_SHIFT     = 3;
  localparam int unsigned SUM_W        = 54;
  localparam int unsigned SUM_SHIFT    = 20;
  localparam int unsigned KT_BOUND_EXP = 50;

  // Register reset values.
  localparam logic signed [ANGLE_W-1:0] TARGET_RST = '0;
  localparam logic [GAIN_W-1:0]  KP_RST    = 16'd6400;
  localparam logic [GAIN_W-1:0]  KI_RST    = 16'd9600;
  localparam logic [LIMIT_W-1:0] LOWER_RST = 12'd1500;
  localparam logic [LIMIT_W-1:0] UPPER_RST = 12'd3000;
  localparam logic [THR_W-1:0]   THR_RST   = 15'd1430;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ANGLE,
    CFG_MOUNT_POSITION,
    CFG_KP,
    CFG_KI,
    CFG_LOWER_LIMIT,
    CFG_UPPER_LIMIT,
    CFG_ERROR_THRESHOLD
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_CHECK,
    ST_MUL_B,
    ST_SUM_A,
    ST_SUM_B,
    ST_SUM_C,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/steer_angle_pi_controller.sv
// Steering-angle PI controller with static feedforward and output clamp.
//
// Input channel: in_valid_i / in_stall_o carries a time step (Q0.16 s) and a
// measured angle (Q2.13 rad). Output channel: out_valid_o / out_stall_i
// carries one servo command and a flag that tells whether the static
// operating point was returned.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i; the
// user must write it only while the block is idle (not enforced by the block);
// a target write, or a mount write that changes the value, clears the integrator.
// Flow: a regulated item passes ST_MUL_A, ST_CHECK, ST_MUL_B, ST_SUM_A,
// ST_SUM_B, ST_SUM_C and ST_DONE; an item whose error exceeds the threshold
// goes from ST_CHECK straight to ST_DONE, then the sequencer returns to idle.
// The work is two rounds of 16-step bit-serial multiplication: the
// map, time-step and proportional products run side by side, then the
// integral product, followed by summing and clamping in ST_SUM_A to ST_SUM_C.
// One item is worked on at a time. A finished result sits in the output
// register, so the next item is accepted while it waits; if the receiver
// still stalls when the following result is done, the sequencer holds.
// Reset clears the integrator, restores the register defaults and empties
// the output register.
`default_nettype none

module steer_angle_pi_controller #(
  parameter int unsigned INTEGRAL_BITS = sapc_pkg::INTEGRAL_BITS_DEF,
  parameter int unsigned SERVO_BITS    = sapc_pkg::SERVO_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [sapc_pkg::TIME_W-1:0]           time_step_i,
  input  logic signed [sapc_pkg::ANGLE_W-1:0]   measured_angle_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [SERVO_BITS-1:0]                 servo_value_o,
  output logic                                  used_static_o,
  input  logic                                  cfg_we_i,
  input  logic [sapc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sapc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned MS       = sapc_pkg::MUL_STEPS;
  localparam int unsigned CNT_W    = $clog2(MS);
  localparam int unsigned ERR_W    = sapc_pkg::ERR_W;
  localparam int unsigned OP_HI_W  = sapc_pkg::MAP_GAIN_W + 2;
  localparam int unsigned OP_P_W   = OP_HI_W + MS;
  localparam int unsigned ERR_HI_W = ERR_W + 1;
  localparam int unsigned ERR_P_W  = ERR_HI_W + MS;
  localparam int unsigned KI_HI_W  = INTEGRAL_BITS + 1;
  localparam int unsigned KI_P_W   = KI_HI_W + MS;
  localparam int unsigned INC_W    = ERR_P_W - sapc_pkg::INC_SHIFT;
  localparam int unsigned ISUM_W   = INTEGRAL_BITS + 1;
  localparam int unsigned MAP_Q_W  = sapc_pkg::MAP_ACC_W - sapc_pkg::MAP_SHIFT;
  localparam int unsigned KT_CL_W  = sapc_pkg::KT_BOUND_EXP + 2;
  localparam int unsigned KT_W     = (KI_P_W > KT_CL_W) ? KI_P_W : KT_CL_W;
  localparam int unsigned SUM_W    = sapc_pkg::SUM_W;
  localparam int unsigned V_W      = SUM_W - sapc_pkg::SUM_SHIFT;
  localparam int unsigned LIMIT_W  = sapc_pkg::LIMIT_W;

  localparam logic signed [KT_W-1:0] KT_HI =
    KT_W'({1'b1, {sapc_pkg::KT_BOUND_EXP{1'b0}}});
  localparam logic signed [KT_W-1:0] KT_LO = -KT_HI;
  localparam logic [SUM_W-1:0] RND_BIAS = SUM_W'({sapc_pkg::SUM_SHIFT{1'b1}});

  // Configuration registers.
  logic signed [sapc_pkg::ANGLE_W-1:0] target_q;
  logic                                mount_q;
  logic [sapc_pkg::GAIN_W-1:0]         kp_q, ki_q;
  logic [LIMIT_W-1:0]                  lower_q, upper_q;
  logic [sapc_pkg::THR_W-1:0]          thr_q;

  // Control state.
  sapc_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic signed [INTEGRAL_BITS-1:0] integral_q, integral_d;

  // Datapath registers.
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [OP_P_W-1:0]       op_p_q, op_p_d;
  logic [ERR_P_W-1:0]      dt_p_q, dt_p_d;
  logic [ERR_P_W-1:0]      kp_p_q, kp_p_d;
  logic [KI_P_W-1:0]       ki_p_q, ki_p_d;
  logic [SERVO_BITS-1:0]   op_q, op_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [SERVO_BITS-1:0]   res_q, res_d;
  logic                    static_q, static_d;
  logic [SERVO_BITS-1:0]   servo_q, servo_d;
  logic                    out_static_q, out_static_d;

  // Combinational intermediates.
  logic                     in_accept, out_free, mul_last;
  logic [sapc_pkg::MAP_GAIN_W-1:0] map_gain;
  logic [sapc_pkg::MAP_ACC_W-1:0]  map_bias, map_acc;
  logic [MAP_Q_W-1:0]       map_q;
  logic [SERVO_BITS-1:0]    op_val;
  logic [OP_HI_W-1:0]       op_hi, op_m, op_t;
  logic [OP_P_W-1:0]        op_step;
  logic [ERR_HI_W-1:0]      err_m, dt_hi, dt_t, kp_hi, kp_t;
  logic [ERR_P_W-1:0]       dt_step, kp_step;
  logic [KI_HI_W-1:0]       ki_hi, ki_m, ki_t;
  logic [KI_P_W-1:0]        ki_step;
  logic [ERR_W-1:0]         mag;
  logic                     too_big;
  logic signed [INC_W-1:0]  inc;
  logic [ISUM_W-1:0]        isum;
  logic signed [INTEGRAL_BITS-1:0] isat;
  logic signed [KT_W-1:0]   kt_full;
  logic signed [KT_CL_W-1:0] kt_cl;
  logic [SUM_W-1:0]         rnd;
  logic signed [V_W-1:0]    v, v_up;
  logic [LIMIT_W-1:0]       v_lim;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign mul_last  = (cnt_q == CNT_W'(MS - 1));

  // Bit-serial multiply lanes: each cycle adds the multiplicand when the low
  // multiplier bit is set, then shifts the product right by one.
  always_comb begin
    map_gain = mount_q ? sapc_pkg::MAP_G1 : sapc_pkg::MAP_G0;
    map_bias = mount_q ? sapc_pkg::MAP_B1 : sapc_pkg::MAP_B0;

    // Target angle is signed, so its top bit carries negative weight.
    op_hi   = op_p_q[OP_P_W-1:MS];
    op_m    = op_p_q[0] ? OP_HI_W'(map_gain) : '0;
    op_t    = mul_last ? (op_hi - op_m) : (op_hi + op_m);
    op_step = {op_t[OP_HI_W-1], op_t, op_p_q[MS-1:1]};

    err_m   = ERR_HI_W'(err_q);
    dt_hi   = dt_p_q[ERR_P_W-1:MS];
    dt_t    = dt_hi + (dt_p_q[0] ? err_m : '0);
    dt_step = {dt_t[ERR_HI_W-1], dt_t, dt_p_q[MS-1:1]};
    kp_hi   = kp_p_q[ERR_P_W-1:MS];
    kp_t    = kp_hi + (kp_p_q[0] ? err_m : '0);
    kp_step = {kp_t[ERR_HI_W-1], kp_t, kp_p_q[MS-1:1]};

    ki_m    = KI_HI_W'(integral_q);
    ki_hi   = ki_p_q[KI_P_W-1:MS];
    ki_t    = ki_hi + (ki_p_q[0] ? ki_m : '0);
    ki_step = {ki_t[KI_HI_W-1], ki_t, ki_p_q[MS-1:1]};
  end

  // Operating point, error check and integrator update.
  always_comb begin
    map_acc = sapc_pkg::MAP_ACC_W'($signed(op_p_q)) + map_bias;
    map_q   = map_acc[sapc_pkg::MAP_ACC_W-1:sapc_pkg::MAP_SHIFT];
    if (map_acc[sapc_pkg::MAP_ACC_W-1]) begin
      op_val = '0;
    end else if (|map_q[MAP_Q_W-1:SERVO_BITS]) begin
      op_val = '1;
    end else begin
      op_val = map_q[SERVO_BITS-1:0];
    end

    mag     = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);
    too_big = (mag > ERR_W'(thr_q));

    // Increment is floored to Q.16; the sum saturates to the integral width.
    inc  = dt_p_q[ERR_P_W-1:sapc_pkg::INC_SHIFT];
    isum = ISUM_W'(integral_q) + ISUM_W'(inc);
    if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
      isat = {isum[ISUM_W-1], {(INTEGRAL_BITS-1){~isum[ISUM_W-1]}}};
    end else begin
      isat = isum[INTEGRAL_BITS-1:0];
    end
  end

  // Regulated sum: bound the integral term, truncate toward zero, clamp.
  always_comb begin
    kt_full = KT_W'($signed(ki_p_q));
    if (kt_full > KT_HI) begin
      kt_cl = KT_CL_W'(KT_HI);
    end else if (kt_full < KT_LO) begin
      kt_cl = KT_CL_W'(KT_LO);
    end else begin
      kt_cl = KT_CL_W'(kt_full);
    end

    rnd  = sum_q + (sum_q[SUM_W-1] ? RND_BIAS : '0);
    v    = rnd[SUM_W-1:sapc_pkg::SUM_SHIFT];
    v_up = (v > $signed(V_W'(upper_q))) ? $signed(V_W'(upper_q)) : v;
    v_lim = (v_up < $signed(V_W'(lower_q))) ? lower_q : v_up[LIMIT_W-1:0];
  end

  // Sequencer: next state and datapath loads.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    err_d        = err_q;
    op_p_d       = op_p_q;
    dt_p_d       = dt_p_q;
    kp_p_d       = kp_p_q;
    ki_p_d       = ki_p_q;
    op_d         = op_q;
    sum_d        = sum_q;
    res_d        = res_q;
    static_d     = static_q;
    integral_d   = integral_q;
    out_valid_d  = out_valid_q && out_stall_i;
    servo_d      = servo_q;
    out_static_d = out_static_q;
    in_stall_o   = (state_q != sapc_pkg::ST_IDLE);

    case (state_q)
      sapc_pkg::ST_IDLE: begin
        if (in_accept) begin
          err_d   = ERR_W'(target_q) - ERR_W'(measured_angle_i);
          op_p_d  = OP_P_W'(unsigned'(target_q));
          dt_p_d  = ERR_P_W'(time_step_i);
          kp_p_d  = ERR_P_W'(kp_q);
          cnt_d   = '0;
          state_d = sapc_pkg::ST_MUL_A;
        end
      end
      sapc_pkg::ST_MUL_A: begin
        op_p_d = op_step;
        dt_p_d = dt_step;
        kp_p_d = kp_step;
        cnt_d  = cnt_q + 1'b1;
        if (mul_last) begin
          state_d = sapc_pkg::ST_CHECK;
        end
      end
      sapc_pkg::ST_CHECK: begin
        op_d = op_val;
        if (too_big) begin
          integral_d = '0;
          res_d      = op_val;
          static_d   = 1'b1;
          state_d    = sapc_pkg::ST_DONE;
        end else begin
          integral_d = isat;
          ki_p_d     = KI_P_W'(ki_q);
          static_d   = 1'b0;
          state_d    = sapc_pkg::ST_MUL_B;
        end
      end
      sapc_pkg::ST_MUL_B: begin
        ki_p_d = ki_step;
        cnt_d  = cnt_q + 1'b1;
        if (mul_last) begin
          state_d = sapc_pkg::ST_SUM_A;
        end
      end
      sapc_pkg::ST_SUM_A: begin
        sum_d = SUM_W'(kt_cl) + (SUM_W'($signed(kp_p_q)) << sapc_pkg::PE_SHIFT);
        state_d = sapc_pkg::ST_SUM_B;
      end
      sapc_pkg::ST_SUM_B: begin
        sum_d   = sum_q + (SUM_W'(op_q) << sapc_pkg::SUM_SHIFT);
        state_d = sapc_pkg::ST_SUM_C;
      end
      sapc_pkg::ST_SUM_C: begin
        res_d   = SERVO_BITS'(v_lim);
        state_d = sapc_pkg::ST_DONE;
      end
      sapc_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          servo_d      = res_q;
          out_static_d = static_q;
          state_d      = sapc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sapc_pkg::ST_IDLE;
      end
    endcase

    // Target writes, and mount writes that change the value, clear the integrator.
    if (cfg_we_i) begin
      if (cfg_index_i == sapc_pkg::CFG_TARGET_ANGLE) begin
        integral_d = '0;
      end else if (cfg_index_i == sapc_pkg::CFG_MOUNT_POSITION &&
                   cfg_data_i[0] != mount_q) begin
        integral_d = '0;
      end
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sapc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      integral_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      integral_q  <= integral_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    err_q        <= err_d;
    op_p_q       <= op_p_d;
    dt_p_q       <= dt_p_d;
    kp_p_q       <= kp_p_d;
    ki_p_q       <= ki_p_d;
    op_q         <= op_d;
    sum_q        <= sum_d;
    res_q        <= res_d;
    static_q     <= static_d;
    servo_q      <= servo_d;
    out_static_q <= out_static_d;
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= sapc_pkg::TARGET_RST;
      mount_q  <= 1'b0;
      kp_q     <= sapc_pkg::KP_RST;
      ki_q     <= sapc_pkg::KI_RST;
      lower_q  <= sapc_pkg::LOWER_RST;
      upper_q  <= sapc_pkg::UPPER_RST;
      thr_q    <= sapc_pkg::THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sapc_pkg::CFG_TARGET_ANGLE:    target_q <= $signed(cfg_data_i);
        sapc_pkg::CFG_MOUNT_POSITION:  mount_q  <= cfg_data_i[0];
        sapc_pkg::CFG_KP:              kp_q     <= cfg_data_i;
        sapc_pkg::CFG_KI:              ki_q     <= cfg_data_i;
        sapc_pkg::CFG_LOWER_LIMIT:     lower_q  <= cfg_data_i[LIMIT_W-1:0];
        sapc_pkg::CFG_UPPER_LIMIT:     upper_q  <= cfg_data_i[LIMIT_W-1:0];
        sapc_pkg::CFG_ERROR_THRESHOLD: thr_q    <= cfg_data_i[sapc_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign servo_value_o = servo_q;
  assign used_static_o = out_static_q;

endmodule

`default_nettype wire

FILE: rtl/core/sapc_chk.sv
// Port-level checker for the steering-angle PI controller, with its bind.
`default_nettype none

module sapc_chk #(
  parameter int unsigned SERVO_BITS = sapc_pkg::SERVO_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [SERVO_BITS-1:0] servo_value_o,
  input logic                  used_static_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(servo_value_o) && $stable(used_static_o))
    else $error("result payload changed while stalled");

  // Only one item is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while one is in work");

  // A fresh result is handed over only as the sequencer returns to idle.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result appeared while the sequencer is busy");

endmodule

bind steer_angle_pi_controller sapc_chk #(.SERVO_BITS(SERVO_BITS)) u_sapc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .servo_value_o (servo_value_o),
  .used_static_o (used_static_o)
);

`default_nettype wire

FILE: verif/tb_steer_angle_pi_controller.sv
// Self-checking testbench for the steering-angle PI controller, with its own predictor.
module tb_steer_angle_pi_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SV_W = sapc_pkg::SERVO_BITS_DEF;
  localparam int unsigned IDX_W = sapc_pkg::CFG_IDX_W;
  localparam int unsigned DATA_W = sapc_pkg::CFG_DATA_W;
  localparam int unsigned ANG_W = sapc_pkg::ANGLE_W;
  localparam int unsigned DT_W = sapc_pkg::TIME_W;
  localparam logic [IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int unsigned RANDOM_SETTINGS = 8;
  localparam int unsigned ITEMS_PER_SETTING = 160;
  localparam int unsigned WINDUP_ITEMS = 150;
  localparam int unsigned MAX_PRINTED = 40;

  // Fixed-point constants of the servo map and of the regulated path.
  localparam longint MAP_GAIN_0 = 64'sd75551085;
  localparam longint MAP_OFS_0  = 64'sd144268842;
  localparam longint MAP_GAIN_1 = 64'sd89879290;
  localparam longint MAP_OFS_1  = 64'sd145407621;
  localparam longint MAP_HALF   = 64'sd1 <<< 28;
  localparam int unsigned MAP_FRAC = 29;
  localparam int unsigned STEP_FRAC = 13;
  localparam int unsigned SUM_FRAC = 20;
  localparam longint SUM_ONE    = 64'sd1 <<< SUM_FRAC;
  localparam longint SERVO_MAX  = (64'sd1 <<< SV_W) - 1;
  localparam longint INTEG_MAX  = (64'sd1 <<< (sapc_pkg::INTEGRAL_BITS_DEF - 1)) - 1;
  localparam longint INTEG_MIN  = -INTEG_MAX - 1;
  localparam longint KI_TERM_MAX = 64'sd1 <<< 50;

  typedef struct packed {
    logic [SV_W-1:0] servo;
    logic            used_static;
  } servo_cmd_t;

  // Predicts each servo command and compares the block's commands in order.
  class servo_scoreboard;
    logic signed [ANG_W-1:0]             target;
    logic                                mount;
    logic [sapc_pkg::GAIN_W-1:0]         kp;
    logic [sapc_pkg::GAIN_W-1:0]         ki;
    logic [sapc_pkg::LIMIT_W-1:0]        lower;
    logic [sapc_pkg::LIMIT_W-1:0]        upper;
    logic [sapc_pkg::THR_W-1:0]          thr;
    longint                              integral;
    servo_cmd_t                          cmd_q[$];
    int unsigned                         err_count;
    int unsigned                         noted;
    int unsigned                         checked;

    function new();
      target = sapc_pkg::TARGET_RST;
      mount = 1'b0;
      kp = sapc_pkg::KP_RST;
      ki = sapc_pkg::KI_RST;
      lower = sapc_pkg::LOWER_RST;
      upper = sapc_pkg::UPPER_RST;
      thr = sapc_pkg::THR_RST;
      integral = 0;
      err_count = 0;
      noted = 0;
      checked = 0;
    endfunction

    function int unsigned pending();
      return cmd_q.size();
    endfunction

    // Register writes; a target write, or a mount change, clears the integrator.
    function void apply_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        sapc_pkg::CFG_TARGET_ANGLE: begin
          target = data;
          integral = 0;
        end
        sapc_pkg::CFG_MOUNT_POSITION: begin
          if (data[0] != mount) begin
            integral = 0;
            mount = data[0];
          end
        end
        sapc_pkg::CFG_KP: kp = data;
        sapc_pkg::CFG_KI: ki = data;
        sapc_pkg::CFG_LOWER_LIMIT: lower = data[sapc_pkg::LIMIT_W-1:0];
        sapc_pkg::CFG_UPPER_LIMIT: upper = data[sapc_pkg::LIMIT_W-1:0];
        sapc_pkg::CFG_ERROR_THRESHOLD: thr = data[sapc_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Static operating point: linear map of the target, rounded half up, saturated.
    function longint operating_point();
      longint acc;
      if (mount)
        acc = MAP_GAIN_1 * longint'(target) + (MAP_OFS_1 <<< STEP_FRAC) + MAP_HALF;
      else
        acc = MAP_GAIN_0 * longint'(target) + (MAP_OFS_0 <<< STEP_FRAC) + MAP_HALF;
      if (acc < 0) return 0;
      acc = acc >>> MAP_FRAC;
      return (acc > SERVO_MAX) ? SERVO_MAX : acc;
    endfunction

    function void note_input(logic [DT_W-1:0] dt, logic signed [ANG_W-1:0] ang);
      longint err;
      longint mag;
      longint op;
      longint kt;
      longint sum;
      longint v;
      servo_cmd_t cmd;
      err = longint'(target) - longint'(ang);
      mag = (err < 0) ? -err : err;
      op = operating_point();
      noted++;
      if (mag > longint'(thr)) begin
        // Error too large: drop the integral and return the operating point.
        integral = 0;
        cmd.servo = op[SV_W-1:0];
        cmd.used_static = 1'b1;
      end else begin
        // Floored increment, saturating integrator.
        integral += (longint'(dt) * err) >>> STEP_FRAC;
        if (integral > INTEG_MAX) integral = INTEG_MAX;
        if (integral < INTEG_MIN) integral = INTEG_MIN;
        kt = longint'(ki) * integral;
        if (kt > KI_TERM_MAX) kt = KI_TERM_MAX;
        if (kt < -KI_TERM_MAX) kt = -KI_TERM_MAX;
        // Sum in Q.20, truncated toward zero, then upper and lower clamps.
        sum = longint'(kp) * err * 8 + kt + (op <<< SUM_FRAC);
        v = sum / SUM_ONE;
        if (v > longint'(upper)) v = longint'(upper);
        if (v < longint'(lower)) v = longint'(lower);
        cmd.servo = v[SV_W-1:0];
        cmd.used_static = 1'b0;
      end
      cmd_q.push_back(cmd);
    endfunction

    task report(string msg);
      err_count++;
      if (err_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [SV_W-1:0] servo, logic st);
      servo_cmd_t want;
      if (cmd_q.size() == 0) begin
        report($sformatf("servo command %0d (static %0b) with no item pending", servo, st));
        return;
      end
      want = cmd_q.pop_front();
      checked++;
      if (servo !== want.servo)
        report($sformatf("command %0d: servo_value %0d, expected %0d",
                         checked, servo, want.servo));
      if (st !== want.used_static)
        report($sformatf("command %0d: used_static %0b, expected %0b",
                         checked, st, want.used_static));
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [DT_W-1:0]         time_step;
  logic signed [ANG_W-1:0] measured_angle;
  logic                    out_valid;
  logic                    out_stall;
  logic [SV_W-1:0]         servo_value;
  logic                    used_static;
  logic                    cfg_we;
  logic [IDX_W-1:0]        cfg_index;
  logic [DATA_W-1:0]       cfg_data;
  bit                      no_idle;
  servo_scoreboard         sb;

  steer_angle_pi_controller i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .time_step_i      (time_step),
    .measured_angle_i (measured_angle),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .servo_value_o    (servo_value),
    .used_static_o    (used_static),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Compare every command taken by the receiver.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(servo_value, used_static);
  end

  // Receiver stalls: mostly short, a few long, and some stall-free stretches.
  initial begin
    int unsigned r;
    int unsigned n;
    logic v;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(99);
      if (no_idle) begin
        v = 1'b0;
        n = 1;
      end else if (r < 20) begin
        v = 1'b0;
        n = $urandom_range(60, 20);
      end else if (r < 65) begin
        v = 1'b0;
        n = $urandom_range(4, 1);
      end else if (r < 93) begin
        v = 1'b1;
        n = $urandom_range(3, 1);
      end else if (r < 98) begin
        v = 1'b1;
        n = $urandom_range(20, 4);
      end else begin
        v = 1'b1;
        n = $urandom_range(150, 30);
      end
      @(negedge clk);
      out_stall <= v;
      repeat (n - 1) @(negedge clk);
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(20_000_000);
    $display("Run timed out with %0d commands still pending.", sb.pending());
    $display("[steer_angle_pi_controller] ERROR");
    $finish;
  end

  // Gap before an item: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 45) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 13);
  endfunction

  // Offer one item and wait until the block takes it.
  task automatic send_item(input logic [DT_W-1:0] dt, input logic signed [ANG_W-1:0] ang);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    time_step <= dt;
    measured_angle <= ang;
    do @(posedge clk); while (in_stall);
    sb.note_input(dt, ang);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Every item returns one command, so an empty queue means the block is idle.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.apply_write(idx, data);
    @(posedge clk);
  endtask

  // Register value: zero, all ones, random, or near the usual setting.
  function automatic logic [15:0] pick_word(logic [15:0] typical);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0000;
    if (r < 20) return 16'hFFFF;
    if (r < 50) return 16'($urandom());
    return typical + 16'($urandom_range(1000)) - 16'd500;
  endfunction

  task automatic shuffle_config();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15)
      write_reg(sapc_pkg::CFG_TARGET_ANGLE, ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000);
    else if (r < 60)
      write_reg(sapc_pkg::CFG_TARGET_ANGLE, 16'(int'($urandom_range(12000)) - 6000));
    else write_reg(sapc_pkg::CFG_TARGET_ANGLE, 16'($urandom()));
    if ($urandom_range(1) != 0) write_reg(sapc_pkg::CFG_MOUNT_POSITION, 16'($urandom()));
    if ($urandom_range(3) != 0) write_reg(sapc_pkg::CFG_KP, pick_word(16'd6400));
    if ($urandom_range(3) != 0) write_reg(sapc_pkg::CFG_KI, pick_word(16'd9600));
    if ($urandom_range(3) != 0) write_reg(sapc_pkg::CFG_LOWER_LIMIT, pick_word(16'd1500));
    if ($urandom_range(3) != 0) write_reg(sapc_pkg::CFG_UPPER_LIMIT, pick_word(16'd3000));
    write_reg(sapc_pkg::CFG_ERROR_THRESHOLD, pick_word(16'd1430));
    if ($urandom_range(3) == 0) write_reg(CFG_IDX_UNUSED, 16'($urandom()));
  endtask

  // Mostly errors within the threshold so the integrator works; the rest anywhere.
  task automatic send_random_item();
    int unsigned r;
    int err;
    int ang;
    logic [DT_W-1:0] dt;
    r = $urandom_range(99);
    dt = (r < 60) ? 16'($urandom()) : 16'($urandom_range(4095));
    r = $urandom_range(99);
    if (r < 80) begin
      err = int'($urandom_range(2 * sb.thr)) - int'(sb.thr);
      ang = int'(sb.target) - err;
      if (ang > 32767) ang = 32767;
      if (ang < -32768) ang = -32768;
    end else begin
      ang = int'($urandom_range(65535)) - 32768;
    end
    send_item(dt, 16'(ang));
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    time_step = '0;
    measured_angle = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero error, threshold edges, field extremes, wind-up both ways.
    send_item(16'h0000, 16'sd0);
    send_item(16'hFFFF, -16'sd1430);
    send_item(16'hFFFF, 16'sd1430);
    send_item(16'h0001, -16'sd1431);
    send_item(16'h8000, 16'sd1431);
    send_item(16'hFFFF, 16'sh8000);
    send_item(16'h7FFF, 16'sh7FFF);
    repeat (6) send_item(16'hFFFF, -16'sd1430);
    repeat (8) send_item(16'hFFFF, 16'sd1430);
    end_burst();
    wait_idle();

    // Largest gains, widest limits, map saturating high on the second mount.
    write_reg(sapc_pkg::CFG_TARGET_ANGLE, 16'h7FFF);
    write_reg(sapc_pkg::CFG_MOUNT_POSITION, 16'h0001);
    write_reg(sapc_pkg::CFG_KP, 16'hFFFF);
    write_reg(sapc_pkg::CFG_KI, 16'hFFFF);
    write_reg(sapc_pkg::CFG_LOWER_LIMIT, 16'h0000);
    write_reg(sapc_pkg::CFG_UPPER_LIMIT, 16'hFFFF);
    write_reg(sapc_pkg::CFG_ERROR_THRESHOLD, 16'hFFFF);
    send_item(16'hFFFF, 16'sd0);
    send_item(16'h0000, 16'sh7FFF);
    send_item(16'h0001, -16'sd1);
    end_burst();
    wait_idle();

    // Map saturating low, same mount rewritten, crossed limits, zero threshold,
    // and a write to an unused index.
    write_reg(sapc_pkg::CFG_TARGET_ANGLE, 16'h8000);
    write_reg(sapc_pkg::CFG_MOUNT_POSITION, 16'hFFFF);
    write_reg(sapc_pkg::CFG_LOWER_LIMIT, 16'h0FFF);
    write_reg(sapc_pkg::CFG_UPPER_LIMIT, 16'h0000);
    write_reg(sapc_pkg::CFG_ERROR_THRESHOLD, 16'h0000);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    send_item(16'hFFFF, 16'sh8000);
    send_item(16'h0064, -16'sd32767);
    send_item(16'hFFFF, 16'sh8000);
    end_burst();
    wait_idle();

    // Long wind-up with the largest increment, first positive, then negative.
    // With ki of one the integral shows directly in the command.
    write_reg(sapc_pkg::CFG_TARGET_ANGLE, 16'h0000);
    write_reg(sapc_pkg::CFG_MOUNT_POSITION, 16'h0000);
    write_reg(sapc_pkg::CFG_KP, 16'hFFFF);
    write_reg(sapc_pkg::CFG_KI, 16'h0001);
    write_reg(sapc_pkg::CFG_LOWER_LIMIT, 16'h0000);
    write_reg(sapc_pkg::CFG_UPPER_LIMIT, 16'h0FFF);
    write_reg(sapc_pkg::CFG_ERROR_THRESHOLD, 16'h7FFF);
    no_idle = 1'b1;
    repeat (WINDUP_ITEMS) send_item(16'hFFFF, -16'sd32767);
    repeat (3) send_item(16'h0000, 16'sd1430);
    repeat (3) send_item(16'hFFFF, 16'sd1430);
    end_burst();
    wait_idle();
    write_reg(sapc_pkg::CFG_TARGET_ANGLE, 16'h0000);
    repeat (WINDUP_ITEMS) send_item(16'hFFFF, 16'sd32767);
    repeat (3) send_item(16'h0000, -16'sd1430);
    repeat (3) send_item(16'hFFFF, -16'sd1430);
    end_burst();
    no_idle = 1'b0;
    wait_idle();

    // Random settings, each followed by a burst of random items.
    for (int unsigned s = 0; s < RANDOM_SETTINGS; s++) begin
      shuffle_config();
      repeat (ITEMS_PER_SETTING) send_random_item();
      end_burst();
      wait_idle();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d items: directed extremes, long wind-up both ways, %0d random settings.",
             sb.noted, RANDOM_SETTINGS);
    $display("Compared %0d servo commands, %0d mismatches.", sb.checked, sb.err_count);
    if (sb.err_count == 0) begin
      $display("[steer_angle_pi_controller] OK");
    end else begin
      $display("[steer_angle_pi_controller] ERROR");
    end
    $finish;
  end

endmodule
